@@ hw/rtl/hcbd_pkg.sv @@
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_T  = 8'h54;

    localparam logic [4:0] TE_LEN = 5'd26;

    // status codes carried by the end-of-response result
    localparam logic [2:0] ST_COMPLETE  = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_NO_ZERO   = 3'd2;
    localparam logic [2:0] ST_NO_HDR    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic [2:0] out_status;
        logic       out_last;
    } result_t;

    // results produced by one request: 0, 1 or 2, in order e0 then e1
    typedef struct packed {
        logic [1:0] cnt;
        result_t    e0;
        result_t    e1;
    } push_t;

    // "Transfer-Encoding: chunked"
    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = "T";
            5'd1:  c = "r";
            5'd2:  c = "a";
            5'd3:  c = "n";
            5'd4:  c = "s";
            5'd5:  c = "f";
            5'd6:  c = "e";
            5'd7:  c = "r";
            5'd8:  c = "-";
            5'd9:  c = "E";
            5'd10: c = "n";
            5'd11: c = "c";
            5'd12: c = "o";
            5'd13: c = "d";
            5'd14: c = "i";
            5'd15: c = "n";
            5'd16: c = "g";
            5'd17: c = ":";
            5'd18: c = " ";
            5'd19: c = "c";
            5'd20: c = "h";
            5'd21: c = "u";
            5'd22: c = "n";
            5'd23: c = "k";
            5'd24: c = "e";
            5'd25: c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/http_chunked_body_decoder_top.sv @@
// HTTP/1.1 chunked body decoder. Takes one response byte per cycle, while s_ready is
// high, on the s_ channel (s_in_last on the final byte) and returns decoded body
// bytes, then one status result with m_out_last set, on the m_ channel. Each byte
// is handled in the cycle it is accepted, so a new byte is taken every cycle that
// s_ready is high; a final byte that is itself a body byte yields two results. A
// four-entry result queue decouples the sides: s_ready drops only while it holds
// over two results; a request's first result is queued the cycle after acceptance.
`default_nettype none

module http_chunked_body_decoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_kind,
    output logic [2:0]      m_out_status,
    output logic            m_out_last
);
    import hcbd_pkg::*;

    push_t   push;
    result_t res;
    logic    space_ok;
    logic    in_acc;

    assign s_ready = space_ok;
    assign in_acc  = s_valid && space_ok;

    hcbd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (in_acc),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push)
    );

    hcbd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (res)
    );

    assign m_out_byte   = res.out_byte;
    assign m_out_kind   = res.out_kind;
    assign m_out_status = res.out_status;
    assign m_out_last   = res.out_last;

endmodule

`default_nettype wire

@@ hw/rtl/hcbd_parser.sv @@
`default_nettype none

module hcbd_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_acc,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    output hcbd_pkg::push_t     push
);
    import hcbd_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR      = 4'd0,
        PH_PASS     = 4'd1,
        PH_SZ_EMPTY = 4'd2,
        PH_SZ_LINE  = 4'd3,
        PH_SZ_LF    = 4'd4,
        PH_DATA     = 4'd5,
        PH_TRAIL_CR = 4'd6,
        PH_TRAIL_LF = 4'd7,
        PH_DONE     = 4'd8,
        PH_OVF      = 4'd9
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [1:0]           blp_reg, blp_next;
    logic [4:0]           pp_reg, pp_next;
    logic                 chunked_reg, chunked_next;
    logic [SIZE_BITS-1:0] cnt_reg, cnt_next;
    logic                 started_reg, started_next;
    logic                 ended_reg, ended_next;

    logic                 do_size, do_data;
    logic                 is_hex, is_ws;
    logic [3:0]           hex_d;
    logic [2:0]           status;
    result_t              data_res, status_res;

    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (in_byte >= "0" && in_byte <= "9") begin
            hex_d = 4'(in_byte - "0");
        end else if (in_byte >= "a" && in_byte <= "f") begin
            hex_d = 4'(in_byte - "a" + 8'd10);
        end else if (in_byte >= "A" && in_byte <= "F") begin
            hex_d = 4'(in_byte - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        is_ws = (in_byte == " ") || (in_byte == 8'h09) || (in_byte == 8'h0A) ||
                (in_byte == 8'h0B) || (in_byte == 8'h0C);
    end

    always_comb begin
        phase_next   = phase_reg;
        blp_next     = blp_reg;
        pp_next      = pp_reg;
        chunked_next = chunked_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        ended_next   = ended_reg;
        do_size      = 1'b0;
        do_data      = 1'b0;
        status       = ST_COMPLETE;

        unique case (phase_reg)
            PH_HDR: begin
                if (in_byte == te_char(pp_reg)) begin
                    if (pp_reg + 5'd1 >= TE_LEN) begin
                        chunked_next = 1'b1;
                        pp_next      = 5'd0;
                    end else begin
                        pp_next = pp_reg + 5'd1;
                    end
                end else begin
                    pp_next = (in_byte == CHAR_T) ? 5'd1 : 5'd0;
                end
                unique case (blp_reg)
                    2'd0: blp_next = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
                    2'd1: blp_next = (in_byte == CHAR_LF) ? 2'd2 :
                                     (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
                    2'd2: blp_next = (in_byte == CHAR_CR) ? 2'd3 : 2'd0;
                    2'd3: begin
                        if (in_byte == CHAR_LF) begin
                            blp_next   = 2'd0;
                            pp_next    = 5'd0;
                            phase_next = chunked_next ? PH_SZ_EMPTY : PH_PASS;
                            cnt_next   = '0;
                        end else begin
                            blp_next = (in_byte == CHAR_CR) ? 2'd1 : 2'd0;
                        end
                    end
                    default: blp_next = 2'd0;
                endcase
            end
            PH_PASS: ;
            PH_SZ_EMPTY, PH_SZ_LINE: do_size = 1'b1;
            PH_SZ_LF: begin
                phase_next = PH_DATA;
                do_data    = (in_byte != CHAR_LF);
            end
            PH_DATA: do_data = 1'b1;
            PH_TRAIL_CR: begin
                if (in_byte == CHAR_CR) phase_next = PH_TRAIL_LF;
                else                    do_size    = 1'b1;
            end
            PH_TRAIL_LF: begin
                if (in_byte == CHAR_LF) phase_next = PH_SZ_EMPTY;
                else                    do_size    = 1'b1;
            end
            default: ;
        endcase

        if (do_data) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SIZE_BITS'(1)) phase_next = PH_TRAIL_CR;
        end

        if (do_size) begin
            if (in_byte == CHAR_CR) begin
                phase_next   = (cnt_reg == '0) ? PH_DONE : PH_SZ_LF;
                started_next = 1'b0;
                ended_next   = 1'b0;
            end else begin
                phase_next = PH_SZ_LINE;
                if (!ended_reg) begin
                    if (is_hex) begin
                        // one more digit would not fit
                        if (cnt_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                            phase_next = PH_OVF;
                        end else begin
                            cnt_next     = {cnt_reg[SIZE_BITS-5:0], hex_d};
                            started_next = 1'b1;
                        end
                    end else if (!(!started_reg && is_ws)) begin
                        ended_next = 1'b1;
                    end
                end
            end
        end

        unique case (phase_next)
            PH_HDR:      status = ST_NO_HDR;
            PH_SZ_LINE:  status = (cnt_next == '0) ? ST_COMPLETE : ST_TRUNC;
            PH_SZ_LF,
            PH_DATA:     status = ST_TRUNC;
            PH_SZ_EMPTY,
            PH_TRAIL_CR,
            PH_TRAIL_LF: status = ST_NO_ZERO;
            PH_OVF:      status = ST_OVERFLOW;
            default:     status = ST_COMPLETE;
        endcase

        // end of response: back to the reset state
        if (in_last) begin
            phase_next   = PH_HDR;
            blp_next     = 2'd0;
            pp_next      = 5'd0;
            chunked_next = 1'b0;
            cnt_next     = '0;
            started_next = 1'b0;
            ended_next   = 1'b0;
        end
    end

    always_comb begin
        data_res   = '{out_byte: in_byte, out_kind: KIND_DATA,
                       out_status: ST_COMPLETE, out_last: 1'b0};
        status_res = '{out_byte: 8'h00, out_kind: KIND_STATUS,
                       out_status: status, out_last: 1'b1};
        push    = '0;
        push.e0 = data_res;
        push.e1 = status_res;
        if (in_acc) begin
            if ((phase_reg == PH_PASS) || do_data) begin
                push.cnt = in_last ? 2'd2 : 2'd1;
            end else if (in_last) begin
                push.cnt = 2'd1;
                push.e0  = status_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            blp_reg     <= 2'd0;
            pp_reg      <= 5'd0;
            chunked_reg <= 1'b0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
        end else if (in_acc) begin
            phase_reg   <= phase_next;
            blp_reg     <= blp_next;
            pp_reg      <= pp_next;
            chunked_reg <= chunked_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            ended_reg   <= ended_next;
        end
    end

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && in_last |=> phase_reg == PH_HDR && cnt_reg == '0 && !chunked_reg)
        else $error("state not cleared after final byte");

    a_data_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> cnt_reg != '0)
        else $error("in chunk data with nothing left to send");

    a_status_iff_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && push.cnt == 2'd2 |-> in_last && push.e1.out_kind == KIND_STATUS)
        else $error("two results without end of response");

endmodule

`default_nettype wire

@@ hw/rtl/hcbd_outq.sv @@
`default_nettype none

module hcbd_outq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hcbd_pkg::push_t push,
    output logic                 space_ok,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output hcbd_pkg::result_t    m_res
);
    import hcbd_pkg::*;

    result_t    mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign m_valid  = (count_reg != 3'd0);
    assign m_res    = mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    // room for a worst-case request of two results
    assign space_ok = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = 2'(wr_ptr_reg + push.cnt);
        rd_ptr_next = 2'(rd_ptr_reg + {1'b0, pop});
        count_next  = 3'(count_reg + {1'b0, push.cnt} - {2'b00, pop});
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem[wr_ptr_reg] <= push.e0;
        if (push.cnt == 2'd2) mem[2'(wr_ptr_reg + 2'd1)] <= push.e1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> space_ok)
        else $error("push without room");

    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 && !pop |=> count_reg != 3'd0)
        else $error("pushed result lost");

endmodule

`default_nettype wire

@@ bench/http_chunked_decode_checker.sv @@
`timescale 1ns / 100ps

module http_chunked_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_out_kind,
    input  logic [2:0] m_out_status,
    input  logic       m_out_last,
    output int         n_fail,
    output int         n_pending
);
    import hcbd_pkg::*;

    localparam int TE_CHARS = 26;
    localparam logic [8*TE_CHARS-1:0] TE_TEXT = "Transfer-Encoding: chunked";

    typedef enum logic [3:0] {
        P_HDR, P_PASS, P_SZ_EMPTY, P_SZ_LINE, P_SZ_LF,
        P_DATA, P_TRAIL_CR, P_TRAIL_LF, P_DONE, P_OVF
    } dec_phase_t;

    dec_phase_t           ph;
    int                   crlf_pos;
    int                   pat_pos;
    bit                   chunked;
    logic [SIZE_BITS-1:0] size_cnt;
    bit                   digits_seen;
    bit                   line_ignored;

    result_t              decoded_q[$];
    result_t              want;
    result_t              got;

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

    function automatic void decoder_reset();
        ph           = P_HDR;
        crlf_pos     = 0;
        pat_pos      = 0;
        chunked      = 1'b0;
        size_cnt     = '0;
        digits_seen  = 1'b0;
        line_ignored = 1'b0;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic kind,
                                        input logic [2:0] st, input logic last);
        result_t r;
        r.out_byte   = b;
        r.out_kind   = kind;
        r.out_status = st;
        r.out_last   = last;
        decoded_q.push_back(r);
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    // space, TAB, LF, VT, FF
    function automatic bit is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C;
    endfunction

    function automatic void scan_header(input logic [7:0] b);
        if (b == TE_TEXT[8*(TE_CHARS-1-pat_pos) +: 8]) begin
            pat_pos++;
            if (pat_pos >= TE_CHARS) begin
                chunked = 1'b1;
                pat_pos = 0;
            end
        end else begin
            pat_pos = (b == CHAR_T) ? 1 : 0;
        end
        case (crlf_pos)
            0: crlf_pos = (b == CHAR_CR) ? 1 : 0;
            1: crlf_pos = (b == CHAR_LF) ? 2 : (b == CHAR_CR) ? 1 : 0;
            2: crlf_pos = (b == CHAR_CR) ? 3 : 0;
            default: begin
                if (b == CHAR_LF) begin
                    crlf_pos = 0;
                    pat_pos  = 0;
                    ph       = chunked ? P_SZ_EMPTY : P_PASS;
                    size_cnt = '0;
                end else begin
                    crlf_pos = (b == CHAR_CR) ? 1 : 0;
                end
            end
        endcase
    endfunction

    function automatic void take_size_char(input logic [7:0] b);
        int d;
        d = hex_value(b);
        if (b == CHAR_CR) begin
            ph           = (size_cnt == 0) ? P_DONE : P_SZ_LF;
            digits_seen  = 1'b0;
            line_ignored = 1'b0;
        end else begin
            ph = P_SZ_LINE;
            if (!line_ignored) begin
                if (d >= 0) begin
                    // one more digit would reach 2^SIZE_BITS
                    if (size_cnt[SIZE_BITS-1 -: 4] != 0) begin
                        ph = P_OVF;
                    end else begin
                        size_cnt    = {size_cnt[SIZE_BITS-5:0], d[3:0]};
                        digits_seen = 1'b1;
                    end
                end else if (digits_seen || !is_blank(b)) begin
                    line_ignored = 1'b1;
                end
            end
        end
    endfunction

    function automatic void take_data(input logic [7:0] b);
        push_result(b, KIND_DATA, ST_COMPLETE, 1'b0);
        size_cnt--;
        if (size_cnt == 0) ph = P_TRAIL_CR;
    endfunction

    function automatic logic [2:0] end_code();
        case (ph)
            P_HDR:                              return ST_NO_HDR;
            P_SZ_LINE:                          return (size_cnt == 0) ? ST_COMPLETE : ST_TRUNC;
            P_SZ_LF, P_DATA:                    return ST_TRUNC;
            P_SZ_EMPTY, P_TRAIL_CR, P_TRAIL_LF: return ST_NO_ZERO;
            P_OVF:                              return ST_OVERFLOW;
            default:                            return ST_COMPLETE;
        endcase
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        case (ph)
            P_HDR:                 scan_header(b);
            P_PASS:                push_result(b, KIND_DATA, ST_COMPLETE, 1'b0);
            P_SZ_EMPTY, P_SZ_LINE: take_size_char(b);
            P_SZ_LF: begin
                ph = P_DATA;
                // no LF after the size line: this byte is already data
                if (b != CHAR_LF) take_data(b);
            end
            P_DATA:                take_data(b);
            P_TRAIL_CR: begin
                if (b == CHAR_CR) ph = P_TRAIL_LF;
                else take_size_char(b);
            end
            P_TRAIL_LF: begin
                if (b == CHAR_LF) ph = P_SZ_EMPTY;
                else take_size_char(b);
            end
            default: ;
        endcase
        if (last) begin
            push_result(8'h00, KIND_STATUS, end_code(), 1'b1);
            decoder_reset();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            decoder_reset();
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready) decode_byte(s_in_byte, s_in_last);
            if (m_valid && m_ready) begin
                got.out_byte   = m_out_byte;
                got.out_kind   = m_out_kind;
                got.out_status = m_out_status;
                got.out_last   = m_out_last;
                if (decoded_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: byte %02h kind %0d status %0d last %0d",
                                 got.out_byte, got.out_kind, got.out_status, got.out_last);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.out_kind !== want.out_kind ||
                        got.out_status !== want.out_status || got.out_last !== want.out_last)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch: expected byte %02h kind %0d status %0d last %0d, %s",
                                     want.out_byte, want.out_kind, want.out_status,
                                     want.out_last,
                                     $sformatf("got byte %02h kind %0d status %0d last %0d",
                                               got.out_byte, got.out_kind, got.out_status,
                                               got.out_last));
                    end
                end
            end
        end
        n_pending = decoded_q.size();
    end

endmodule

@@ bench/tb_http_chunked_body_decoder_top.sv @@
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_top;
    import hcbd_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         RANDOM_BYTES = 40;
    localparam logic [7:0] TAB_CHAR     = 8'h09;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SCARCE} rdy_mode_t;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte    = 8'h00;
    logic       s_in_last    = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_kind;
    logic [2:0] m_out_status;
    logic       m_out_last;

    int         n_fail;
    int         n_pending;
    int         cycle_cnt    = 0;
    int         burst_left   = 0;
    int         bytes_sent   = 0;
    int         rdy_left     = 0;
    rdy_mode_t  rdy_mode     = RDY_ALWAYS;
    logic [7:0] resp_q[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    http_chunked_body_decoder_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_kind   (m_out_kind),
        .m_out_status (m_out_status),
        .m_out_last   (m_out_last)
    );

    http_chunked_decode_checker i_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_kind   (m_out_kind),
        .m_out_status (m_out_status),
        .m_out_last   (m_out_last),
        .n_fail       (n_fail),
        .n_pending    (n_pending)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure, changing character every so often
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 3));
            rdy_left = $urandom_range(16, 160);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
            default:    m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid   <= 1'b0;
                s_in_byte <= 8'($urandom_range(0, 255));
                s_in_last <= 1'($urandom_range(0, 1));
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_response();
        for (int i = 0; i < resp_q.size(); i++)
            send_byte(resp_q[i], i == resp_q.size() - 1);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) resp_q.push_back(s[i]);
    endtask

    task automatic add_crlf();
        resp_q.push_back(CHAR_CR);
        resp_q.push_back(CHAR_LF);
    endtask

    function automatic logic [7:0] hex_ascii(input logic [3:0] d, input bit upper);
        if (d < 10) return 8'h30 + d;
        return (upper ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
    endfunction

    task automatic add_hex(input logic [35:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            resp_q.push_back(hex_ascii(v[4*i +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic add_filler(input int lines);
        repeat (lines) begin
            repeat ($urandom_range(1, 8)) resp_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            add_crlf();
        end
    endtask

    task automatic new_chunked_response();
        resp_q.delete();
        add_text("Transfer-Encoding: chunked");
        add_crlf();
        add_crlf();
    endtask

    task automatic build_random_response();
        int          pick;
        int          n_chunks;
        int          sz;
        int          digits;
        logic [35:0] big;
        logic [31:0] rnd;
        bit          cut_short;
        resp_q.delete();
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            repeat ($urandom_range(1, 24)) resp_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_filler($urandom_range(0, 2));
            if (pick < 7) begin
                if ($urandom_range(0, 3) == 0) add_text("T");
                add_text("Transfer-Encoding: chunked");
                add_crlf();
            end else if (pick == 7) begin
                // near miss, body stays plain
                add_text("Transfer-Encoding: chunke");
                add_crlf();
            end
            add_filler($urandom_range(0, 1));
            add_crlf();
            if (pick >= 7) begin
                repeat ($urandom_range(0, 16)) resp_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                cut_short = 1'b0;
                n_chunks  = $urandom_range(0, 4);
                for (int c = 0; c < n_chunks && !cut_short; c++) begin
                    if ($urandom_range(0, 4) == 0)
                        resp_q.push_back($urandom_range(0, 1) ? TAB_CHAR : 8'h20);
                    pick = $urandom_range(0, 19);
                    rnd  = $urandom;
                    if (pick == 0) begin
                        // nine significant digits cannot fit the size counter
                        big = {4'h1 + (rnd[3:0] % 4'hF), rnd};
                        add_hex(big, 9);
                        add_crlf();
                        repeat ($urandom_range(0, 4))
                            resp_q.push_back(8'($urandom_range(0, 255)));
                        cut_short = 1'b1;
                    end else if (pick == 1) begin
                        big = {4'h0, 4'h1 + (rnd[31:28] % 4'hF), rnd[27:0]};
                        add_hex(big, 8);
                        add_crlf();
                        repeat ($urandom_range(0, 5))
                            resp_q.push_back(8'($urandom_range(0, 255)));
                        cut_short = 1'b1;
                    end else begin
                        sz     = $urandom_range(1, 6);
                        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 9) : 1;
                        add_hex(36'(sz), digits);
                        if ($urandom_range(0, 4) == 0) add_text(";ext=1");
                        resp_q.push_back(CHAR_CR);
                        if ($urandom_range(0, 9) != 0) resp_q.push_back(CHAR_LF);
                        repeat (sz) resp_q.push_back(8'($urandom_range(0, 255)));
                        pick = $urandom_range(0, 9);
                        if (pick < 8) add_crlf();
                        else if (pick == 8) resp_q.push_back(CHAR_CR);
                    end
                end
                if (!cut_short && $urandom_range(0, 6) != 0) begin
                    add_text("0");
                    add_crlf();
                    add_crlf();
                end
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 6)) resp_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            sz = $urandom_range(1, resp_q.size());
            while (resp_q.size() > sz) void'(resp_q.pop_back());
        end
    endtask

    initial begin
        int n_resp;
        int stop_at;
        n_resp = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ends inside the header
        resp_q.delete();
        resp_q.push_back(8'hFF);
        send_response();
        resp_q.delete();
        resp_q.push_back(8'h00);
        send_response();

        // plain body passes through
        resp_q.delete();
        add_crlf();
        add_crlf();
        resp_q.push_back(8'h00);
        resp_q.push_back(8'hFF);
        resp_q.push_back(8'h55);
        resp_q.push_back(8'hAA);
        send_response();

        // false start on the pattern, CR CR LF CR LF, blanks and an extension
        resp_q.delete();
        add_text("TTransfer-Encoding: chunked");
        resp_q.push_back(CHAR_CR);
        add_crlf();
        add_crlf();
        resp_q.push_back(8'h20);
        resp_q.push_back(TAB_CHAR);
        add_text("3;ext");
        add_crlf();
        add_text("abc");
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        send_response();

        // no LF after the size, no LF after the data
        new_chunked_response();
        add_text("a");
        resp_q.push_back(CHAR_CR);
        add_text("0123456789");
        add_text("2");
        add_crlf();
        add_text("xy");
        resp_q.push_back(CHAR_CR);
        add_text("0");
        add_crlf();
        send_response();

        // size overflow
        new_chunked_response();
        add_text("123456789");
        add_crlf();
        add_text("zz");
        send_response();

        // largest size, cut short in the data
        new_chunked_response();
        add_text("FFFFFFFF");
        add_crlf();
        add_text("ab");
        send_response();

        // ends on a chunk boundary
        new_chunked_response();
        add_text("1");
        add_crlf();
        add_text("q");
        send_response();

        // ends right at the first size line
        new_chunked_response();
        send_response();

        // ends inside a nonzero size line, then after its CR
        new_chunked_response();
        add_text("5");
        send_response();
        new_chunked_response();
        add_text("5");
        resp_q.push_back(CHAR_CR);
        send_response();

        // 0x prefix, sign and empty size line all read as size zero
        new_chunked_response();
        add_text("0x10");
        add_crlf();
        add_text("hi");
        send_response();
        new_chunked_response();
        add_text("-5");
        add_crlf();
        add_text("ab");
        add_crlf();
        send_response();
        new_chunked_response();
        add_crlf();
        add_text("ab");
        send_response();

        // leading zeros beyond the counter width
        new_chunked_response();
        add_text("0000000002");
        add_crlf();
        add_text("ok");
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        send_response();

        drain_results();

        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            build_random_response();
            send_response();
            n_resp++;
            if (n_resp % 5 == 0) drain_results();
        end

        drain_results();
        repeat (16) @(negedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
